[hw/rtl/pvo_pkg.sv]
package pvo_pkg;

  // Default ring capacity.
  localparam int MAX_VERTICES_DEF = 64;

  // Offset distance after reset: 20.0 in Q16.16.
  localparam logic signed [31:0] RADIUS_RST = 32'sd1310720;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // One input request: a ring vertex.
  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic               in_last;
  } pvo_req_t;

  // One result: an offset vertex.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               out_last;
    logic [1:0]         status;
  } pvo_res_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_PREV,
    S_RD_CUR,
    S_RD_NEXT,
    S_LAT_NEXT,
    S_NORM_A,
    S_WAIT_A,
    S_NORM_B,
    S_WAIT_B,
    S_NORM_D,
    S_WAIT_D,
    S_MUL_X,
    S_MUL_Y,
    S_EMIT
  } pvo_state_t;

  // Which vertex a store access concerns: the current one or one of its two neighbors.
  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_sel_t;

  // Which vector the normalizer works on.
  typedef enum logic [1:0] {
    VEC_A,
    VEC_B,
    VEC_D
  } vec_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     lat_en;
    rd_sel_t  lat_sel;
    logic     vtx_begin;
    logic     norm_start;
    logic     norm_cap;
    vec_sel_t vec_sel;
    logic     mul_x;
    logic     mul_y;
    logic     emit;
    logic     step;
    logic     ring_done;
  } pvo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic norm_done;
    logic last_idx;
  } pvo_stat_t;

endpackage

[hw/rtl/polygon_vertex_offset.sv]
// Loading accepts one vertex request per cycle; busy stays low, so vertices may come back to back.
// The flagged last vertex starts the emit pass, with busy high until the final result.
// Each result takes three passes through the shared normalize unit (shift search, 32-step square
// root, 32-step divider) plus reads, multiplies and emit; a zero-length vector skips the search,
// root and divider steps of the unit.
// The receiver cannot stall. Synchronous reset clears the ring and sets the radius to 20.0.
module polygon_vertex_offset #(
  parameter int MAX_VERTICES = pvo_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pvo_pkg::pvo_req_t req,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  output pvo_pkg::pvo_res_t res,
  output logic              result_strobe
);

  pvo_pkg::pvo_cmd_t  cmd;
  pvo_pkg::pvo_stat_t stat;

  pvo_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_last (req.in_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  pvo_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .res           (res),
    .result_strobe (result_strobe)
  );

endmodule

[hw/rtl/pvo_norm.sv]
module pvo_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] vin_x,
  input  logic signed [33:0] vin_y,
  output logic               done,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy,
  output logic               zero
);

  typedef enum logic [3:0] {
    N_IDLE,
    N_SHIFT,
    N_SQX,
    N_SQY,
    N_SUM,
    N_SQRT,
    N_DIVSET,
    N_DIV,
    N_DONE
  } norm_phase_t;

  norm_phase_t phase;
  logic [32:0] mx;
  logic [32:0] my;
  logic        sx;
  logic        sy;
  logic [61:0] prod;
  logic [63:0] v;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [31:0] rx;
  logic [31:0] ry;
  logic [31:0] qx;
  logic [31:0] qy;
  logic [4:0]  cnt;
  logic        zero_r;

  logic [33:0] abs_x;
  logic [33:0] abs_y;
  logic [32:0] mmax;
  logic [63:0] trial;
  logic        sq_ge;
  logic [61:0] num_x;
  logic [61:0] num_y;
  logic [32:0] tx;
  logic [32:0] ty;
  logic        gex;
  logic        gey;

  // Magnitudes of the incoming vector and the larger of the two held ones.
  always_comb begin
    abs_x = vin_x[33] ? 34'(-vin_x) : 34'(vin_x);
    abs_y = vin_y[33] ? 34'(-vin_y) : 34'(vin_y);
    mmax  = (mx > my) ? mx : my;
  end

  // One digit of the square root.
  always_comb begin
    trial = root + bitv;
    sq_ge = (v >= trial);
  end

  // Rounded numerators and one restoring division step for each component.
  always_comb begin
    num_x = 62'({mx[30:0], 30'b0}) + 62'(root[31:1]);
    num_y = 62'({my[30:0], 30'b0}) + 62'(root[31:1]);
    tx    = {rx, qx[31]};
    ty    = {ry, qy[31]};
    gex   = (tx >= {1'b0, root[31:0]});
    gey   = (ty >= {1'b0, root[31:0]});
  end

  // Sequencer of the shared normalize unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= N_IDLE;
    end else begin
      case (phase)
        N_IDLE: begin
          if (start) begin
            phase <= ((abs_x == '0) && (abs_y == '0)) ? N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          if ((mmax[32:31] == 2'b00) && mmax[30]) begin
            phase <= N_SQX;
          end
        end
        N_SQX:    phase <= N_SQY;
        N_SQY:    phase <= N_SUM;
        N_SUM:    phase <= N_SQRT;
        N_SQRT: begin
          if (cnt == 5'd31) begin
            phase <= N_DIVSET;
          end
        end
        N_DIVSET: phase <= N_DIV;
        N_DIV: begin
          if (cnt == 5'd31) begin
            phase <= N_DONE;
          end
        end
        N_DONE:   phase <= N_IDLE;
        default:  phase <= N_IDLE;
      endcase
    end
  end

  // Working registers of the unit.
  always_ff @(posedge clk) begin
    case (phase)
      N_IDLE: begin
        mx     <= abs_x[32:0];
        my     <= abs_y[32:0];
        sx     <= vin_x[33];
        sy     <= vin_y[33];
        qx     <= '0;
        qy     <= '0;
        cnt    <= '0;
        zero_r <= (abs_x == '0) && (abs_y == '0);
      end
      N_SHIFT: begin
        // Bring the larger magnitude into [2^30, 2^31), one bit a cycle.
        if (mmax[32:31] != 2'b00) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end else if (!mmax[30]) begin
          mx <= mx << 1;
          my <= my << 1;
        end
      end
      N_SQX: begin
        prod <= 62'(mx[30:0]) * 62'(mx[30:0]);
      end
      N_SQY: begin
        v    <= 64'(prod);
        prod <= 62'(my[30:0]) * 62'(my[30:0]);
      end
      N_SUM: begin
        v    <= v + 64'(prod);
        root <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
      end
      N_SQRT: begin
        if (sq_ge) begin
          v    <= v - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
      end
      N_DIVSET: begin
        rx  <= 32'(num_x[61:32]);
        qx  <= num_x[31:0];
        ry  <= 32'(num_y[61:32]);
        qy  <= num_y[31:0];
        cnt <= '0;
      end
      N_DIV: begin
        rx  <= gex ? 32'(tx - {1'b0, root[31:0]}) : tx[31:0];
        qx  <= {qx[30:0], gex};
        ry  <= gey ? 32'(ty - {1'b0, root[31:0]}) : ty[31:0];
        qy  <= {qy[30:0], gey};
        cnt <= cnt + 5'd1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Signed unit components in Q2.30.
  assign done = (phase == N_DONE);
  assign ux   = sx ? -$signed(qx) : $signed(qx);
  assign uy   = sy ? -$signed(qy) : $signed(qy);
  assign zero = zero_r;

endmodule

[hw/rtl/pvo_datapath.sv]
module pvo_datapath #(
  parameter int MAX_VERTICES = pvo_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pvo_pkg::pvo_req_t  req,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  pvo_pkg::pvo_cmd_t  cmd,
  output pvo_pkg::pvo_stat_t stat,
  output pvo_pkg::pvo_res_t  res,
  output logic               result_strobe
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [63:0]        mem [MAX_VERTICES];
  logic [63:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      count;
  logic [CW-1:0]      cnt_m1;
  logic               ovf;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      last_addr;
  logic [AW-1:0]      prev_addr;
  logic [AW-1:0]      next_addr;
  logic               last_idx;
  logic               room;
  logic signed [31:0] radius;

  logic signed [31:0] prv_x, prv_y, cur_x, cur_y, nxt_x, nxt_y;
  logic signed [31:0] ua_x, ua_y, ub_x, ub_y, ud_x, ud_y;
  logic               deg;

  logic signed [33:0] vin_x;
  logic signed [33:0] vin_y;
  logic               n_done;
  logic signed [31:0] n_ux;
  logic signed [31:0] n_uy;
  logic               n_zero;

  logic [31:0]        r_abs;
  logic signed [31:0] d_sel;
  logic [31:0]        d_neg;
  logic [30:0]        d_abs;
  logic [62:0]        prod;
  logic               prod_neg;
  logic [62:0]        rnd;
  logic [34:0]        q;
  logic signed [34:0] off;
  logic signed [31:0] base;
  logic signed [34:0] sum;
  logic signed [31:0] sat_val;

  // Ring bookkeeping: fill count and overflow mark.
  assign room = (count < CW'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.ring_done) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Offset distance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= pvo_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      radius <= cfg_data;
    end
  end

  // Vertex index of the result being worked on.
  always_ff @(posedge clk) begin
    if (rst || cmd.ring_done) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + AW'(1);
    end
  end

  // Neighbor addresses with wraparound at the ring ends.
  always_comb begin
    cnt_m1    = count - CW'(1);
    last_addr = cnt_m1[AW-1:0];
    last_idx  = (CW'(idx) == cnt_m1);
    prev_addr = (idx == '0) ? last_addr : idx - AW'(1);
    next_addr = last_idx ? '0 : idx + AW'(1);
    case (cmd.rd_sel)
      pvo_pkg::RD_PREV: rd_addr = prev_addr;
      pvo_pkg::RD_CUR:  rd_addr = idx;
      pvo_pkg::RD_NEXT: rd_addr = next_addr;
      default:          rd_addr = idx;
    endcase
  end

  assign stat.last_idx  = last_idx;
  assign stat.norm_done = n_done;

  // Vertex store: x in the low half, y in the high half.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[count[AW-1:0]] <= {req.in_y, req.in_x};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Capture the three vertices around the current one.
  always_ff @(posedge clk) begin
    if (cmd.lat_en) begin
      case (cmd.lat_sel)
        pvo_pkg::RD_PREV: begin
          prv_x <= rd_data[31:0];
          prv_y <= rd_data[63:32];
        end
        pvo_pkg::RD_CUR: begin
          cur_x <= rd_data[31:0];
          cur_y <= rd_data[63:32];
        end
        default: begin
          nxt_x <= rd_data[31:0];
          nxt_y <= rd_data[63:32];
        end
      endcase
    end
  end

  // Select the vector to normalize: incoming edge, outgoing edge or bisector.
  always_comb begin
    case (cmd.vec_sel)
      pvo_pkg::VEC_A: begin
        vin_x = 34'(cur_x) - 34'(prv_x);
        vin_y = 34'(cur_y) - 34'(prv_y);
      end
      pvo_pkg::VEC_B: begin
        vin_x = 34'(nxt_x) - 34'(cur_x);
        vin_y = 34'(nxt_y) - 34'(cur_y);
      end
      default: begin
        vin_x = -34'(ua_y) - 34'(ub_y);
        vin_y = 34'(ua_x) + 34'(ub_x);
      end
    endcase
  end

  pvo_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .vin_x (vin_x),
    .vin_y (vin_y),
    .done  (n_done),
    .ux    (n_ux),
    .uy    (n_uy),
    .zero  (n_zero)
  );

  // Keep the unit vectors and note any zero-length vector.
  always_ff @(posedge clk) begin
    if (cmd.vtx_begin) begin
      deg <= 1'b0;
    end else if (cmd.norm_cap && n_zero) begin
      deg <= 1'b1;
    end
    if (cmd.norm_cap) begin
      case (cmd.vec_sel)
        pvo_pkg::VEC_A: begin
          ua_x <= n_ux;
          ua_y <= n_uy;
        end
        pvo_pkg::VEC_B: begin
          ub_x <= n_ux;
          ub_y <= n_uy;
        end
        default: begin
          ud_x <= n_ux;
          ud_y <= n_uy;
        end
      endcase
    end
  end

  // Offset product: |radius| times |d|, one component a cycle.
  always_comb begin
    r_abs = radius[31] ? 32'(-radius) : 32'(radius);
    d_sel = cmd.mul_y ? ud_y : ud_x;
    d_neg = 32'(-d_sel);
    d_abs = d_sel[31] ? d_neg[30:0] : d_sel[30:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod     <= 63'(r_abs) * 63'(d_abs);
      prod_neg <= radius[31] ^ d_sel[31];
    end
  end

  // Round half away from zero, add to the original vertex and saturate.
  always_comb begin
    rnd  = prod + 63'(64'h2000_0000);
    q    = 35'(rnd[62:30]);
    off  = prod_neg ? -$signed(q) : $signed(q);
    base = cmd.emit ? cur_y : cur_x;
    sum  = 35'(base) + off;
    if (sum > 35'sd2147483647) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (sum < -35'sd2147483648) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = sum[31:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.mul_y) begin
      res.out_x <= sat_val;
    end
    if (cmd.emit) begin
      res.out_y    <= sat_val;
      res.out_last <= last_idx;
      res.status   <= ovf ? pvo_pkg::ST_OVF : (deg ? pvo_pkg::ST_DEGEN : pvo_pkg::ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  // A result takes many cycles, so strobes never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for two cycles");

  // The ring state is clear once its final result shows.
  a_ring_cleared: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && res.out_last) |-> (count == '0) && !ovf && (idx == '0))
    else $error("ring state not cleared after final result");

  // The store is never read past the fill count.
  a_read_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (CW'(rd_addr) < count))
    else $error("vertex store read beyond the ring");

endmodule

[hw/rtl/pvo_ctrl.sv]
module pvo_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               in_last,
  input  pvo_pkg::pvo_stat_t stat,
  output pvo_pkg::pvo_cmd_t  cmd,
  output logic               busy
);

  pvo_pkg::pvo_state_t state;
  pvo_pkg::pvo_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_sel  = pvo_pkg::RD_CUR;
    cmd.lat_sel = pvo_pkg::RD_CUR;
    cmd.vec_sel = pvo_pkg::VEC_A;
    busy        = 1'b1;
    case (state)
      pvo_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = pvo_pkg::S_RD_PREV;
          end
        end
      end
      pvo_pkg::S_RD_PREV: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pvo_pkg::RD_PREV;
        state_next = pvo_pkg::S_RD_CUR;
      end
      pvo_pkg::S_RD_CUR: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = pvo_pkg::RD_CUR;
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = pvo_pkg::RD_PREV;
        state_next  = pvo_pkg::S_RD_NEXT;
      end
      pvo_pkg::S_RD_NEXT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = pvo_pkg::RD_NEXT;
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = pvo_pkg::RD_CUR;
        state_next  = pvo_pkg::S_LAT_NEXT;
      end
      pvo_pkg::S_LAT_NEXT: begin
        cmd.lat_en    = 1'b1;
        cmd.lat_sel   = pvo_pkg::RD_NEXT;
        cmd.vtx_begin = 1'b1;
        state_next    = pvo_pkg::S_NORM_A;
      end
      pvo_pkg::S_NORM_A: begin
        cmd.norm_start = 1'b1;
        cmd.vec_sel    = pvo_pkg::VEC_A;
        state_next     = pvo_pkg::S_WAIT_A;
      end
      pvo_pkg::S_WAIT_A: begin
        cmd.vec_sel  = pvo_pkg::VEC_A;
        cmd.norm_cap = stat.norm_done;
        if (stat.norm_done) begin
          state_next = pvo_pkg::S_NORM_B;
        end
      end
      pvo_pkg::S_NORM_B: begin
        cmd.norm_start = 1'b1;
        cmd.vec_sel    = pvo_pkg::VEC_B;
        state_next     = pvo_pkg::S_WAIT_B;
      end
      pvo_pkg::S_WAIT_B: begin
        cmd.vec_sel  = pvo_pkg::VEC_B;
        cmd.norm_cap = stat.norm_done;
        if (stat.norm_done) begin
          state_next = pvo_pkg::S_NORM_D;
        end
      end
      pvo_pkg::S_NORM_D: begin
        cmd.norm_start = 1'b1;
        cmd.vec_sel    = pvo_pkg::VEC_D;
        state_next     = pvo_pkg::S_WAIT_D;
      end
      pvo_pkg::S_WAIT_D: begin
        cmd.vec_sel  = pvo_pkg::VEC_D;
        cmd.norm_cap = stat.norm_done;
        if (stat.norm_done) begin
          state_next = pvo_pkg::S_MUL_X;
        end
      end
      pvo_pkg::S_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = pvo_pkg::S_MUL_Y;
      end
      pvo_pkg::S_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        state_next = pvo_pkg::S_EMIT;
      end
      pvo_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last_idx) begin
          cmd.ring_done = 1'b1;
          state_next    = pvo_pkg::S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = pvo_pkg::S_RD_PREV;
        end
      end
      default: begin
        state_next = pvo_pkg::S_IDLE;
      end
    endcase
  end

  // The normalizer only finishes while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.norm_done |-> (state == pvo_pkg::S_WAIT_A || state == pvo_pkg::S_WAIT_B ||
                        state == pvo_pkg::S_WAIT_D))
    else $error("normalizer finished outside a wait state");

  // A closing vertex starts the emit pass.
  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_last) |=> (busy && state == pvo_pkg::S_RD_PREV))
    else $error("closing vertex did not start the emit pass");

  // Only one normalizer step is requested at a time.
  a_one_norm_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.norm_start |-> !cmd.norm_cap && !cmd.load && busy)
    else $error("normalizer started while capturing or loading");

endmodule
